// ===== sv/hvn_pkg.sv =====
// Package for the height grid vertex normal block.
// Holds reset values, register indexes, arithmetic widths and constants.
// No dependencies.
package hvn_pkg;

  localparam int MAX_ORDER_DEF = 7;

  localparam int HGT_W  = 16;
  localparam int NRM_W  = 16;
  localparam int SQ_W   = 32;
  localparam int N2_W   = 34;
  localparam int UNIT_W = 15;
  localparam int ACC_W  = 18;

  localparam logic [15:0] SPACING_RST = 16'd256;
  localparam logic [2:0]  ORDER_RST   = 3'd7;

  localparam logic CFG_SPACING = 1'b0;
  localparam logic CFG_ORDER   = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Reciprocal of three: floor(a / 3) == (a * DIV3_MUL) >> DIV3_SHIFT for a < 2^19.
  localparam logic [17:0] DIV3_MUL   = 18'd174763;
  localparam int          DIV3_SHIFT = 19;

endpackage

// ===== sv/hvn_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16641
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/hvn_unit.sv =====
// Unit-length component: round(|c| * 2^14 / sqrt(N)) from c^2 and N.
// Iterative restoring divide (one quotient bit a cycle), then bitwise square root.
// Depends on hvn_pkg.
module hvn_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [hvn_pkg::SQ_W-1:0]        m,
  input  logic [hvn_pkg::N2_W-1:0]        n2,
  output logic                            done,
  output logic [hvn_pkg::UNIT_W-1:0]      r
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_DIV  = 2'd1;
  localparam logic [1:0] U_SQRT = 2'd2;

  logic [1:0]                     st_r, st_nxt;
  logic [hvn_pkg::N2_W-1:0]       rem_r, rem_nxt;
  logic [hvn_pkg::N2_W-1:0]       d_r, d_nxt;
  logic                           nz_r, nz_nxt;
  logic [30:0]                    q_r, q_nxt;
  logic [4:0]                     cnt_r, cnt_nxt;
  logic [31:0]                    v_r, v_nxt;
  logic [31:0]                    res_r, res_nxt;
  logic [30:0]                    bit_r, bit_nxt;
  logic                           done_r, done_nxt;
  logic [hvn_pkg::UNIT_W-1:0]     out_r, out_nxt;

  logic [hvn_pkg::N2_W:0]         m_ext;
  logic [hvn_pkg::N2_W:0]         rem2;
  logic                           ge;
  logic [31:0]                    trial;
  logic [31:0]                    res_step;
  logic [32:0]                    rnd;

  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    nz_nxt   = nz_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    done_nxt = 1'b0;
    out_nxt  = out_r;
    m_ext    = (hvn_pkg::N2_W + 1)'(m);
    rem2     = {rem_r, 1'b0};
    ge       = nz_r && (rem2 >= {1'b0, d_r});
    trial    = res_r + 32'(bit_r);
    res_step = 32'd0;
    rnd      = 33'd0;
    unique case (st_r)
      U_IDLE: begin
        if (start) begin
          d_nxt  = n2;
          nz_nxt = (n2 != '0);
          if (n2 == '0) begin
            rem_nxt = '0;
            q_nxt   = 31'd0;
          end else if (m_ext >= {1'b0, n2}) begin
            rem_nxt = hvn_pkg::N2_W'(m_ext - {1'b0, n2});
            q_nxt   = 31'd1;
          end else begin
            rem_nxt = hvn_pkg::N2_W'(m_ext);
            q_nxt   = 31'd0;
          end
          cnt_nxt = 5'd0;
          st_nxt  = U_DIV;
        end
      end
      U_DIV: begin
        rem_nxt = ge ? hvn_pkg::N2_W'(rem2 - {1'b0, d_r}) : hvn_pkg::N2_W'(rem2);
        q_nxt   = {q_r[29:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd29) begin
          v_nxt   = {1'b0, q_nxt};
          res_nxt = 32'd0;
          bit_nxt = 31'h4000_0000;
          cnt_nxt = 5'd0;
          st_nxt  = U_SQRT;
        end
      end
      U_SQRT: begin
        if (v_r >= trial) begin
          v_nxt    = v_r - trial;
          res_step = (res_r >> 1) + 32'(bit_r);
        end else begin
          res_step = res_r >> 1;
        end
        res_nxt = res_step;
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          rnd      = ({1'b0, res_step} + 33'd1) >> 1;
          out_nxt  = rnd[hvn_pkg::UNIT_W-1:0];
          done_nxt = 1'b1;
          st_nxt   = U_IDLE;
        end
      end
      default: begin
        st_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    nz_r  <= nz_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    out_r <= out_nxt;
  end

  assign done = done_r;
  assign r    = out_r;

endmodule

// ===== sv/heightmap_vertex_normal.sv =====
// Vertex normals of a square height grid held in one synchronous RAM.
// A write is stored at its accept edge; a read beyond the grid goes to the done state and then to the output register.
// A valid read fetches 7 heights, then for each adjacent triangle passes its 3 components
// in turn through the shared divide and square-root unit and averages the results per
// component; one read is in work at a time.
// Synchronous active-low reset clears control state; the height RAM is not cleared.
module heightmap_vertex_normal #(
  parameter int MAX_ORDER = hvn_pkg::MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coord_x[7:0], coord_y[15:8], height_value[31:16]
  input  logic        in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // normal_x[15:0], normal_y[31:16], normal_z[47:32]
  output logic        out_tuser,  // coord_error[0]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int SIDE  = (1 << MAX_ORDER) + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NB    = (MAX_ORDER + 2 > 9) ? MAX_ORDER + 2 : 9;
  localparam logic [3:0] MAX_ORD4 = 4'(MAX_ORDER);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_TRI   = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_UNIT  = 3'd4;
  localparam logic [2:0] S_AVG   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  function automatic logic [AW-1:0] addr_of(input logic [8:0] px, input logic [8:0] py);
    return AW'(int'(px) * SIDE + int'(py));
  endfunction

  function automatic logic signed [16:0] diff(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    return 17'($signed({a[15], a}) - $signed({b[15], b}));
  endfunction

  function automatic logic [15:0] avg_comp(input logic signed [17:0] sum,
                                           input logic [2:0] cnt);
    logic [17:0] neg;
    logic [16:0] mag;
    logic [17:0] v;
    logic [16:0] a;
    logic [34:0] p;
    logic [16:0] q;
    logic [16:0] res;
    neg = 18'(-sum);
    mag = sum[17] ? neg[16:0] : sum[16:0];
    v   = {mag, 1'b0} + 18'(cnt);
    a   = v[17:1];
    q   = v[17:1];
    p   = 35'd0;
    case (cnt)
      3'd1: q = v[17:1];
      3'd2: q = {1'b0, v[17:2]};
      3'd3: begin
        a = v[17:1];
        p = 35'(a) * 35'(hvn_pkg::DIV3_MUL);
        q = 17'(p >> hvn_pkg::DIV3_SHIFT);
      end
      default: begin
        a = {1'b0, v[17:2]};
        p = 35'(a) * 35'(hvn_pkg::DIV3_MUL);
        q = 17'(p >> hvn_pkg::DIV3_SHIFT);
      end
    endcase
    res = sum[17] ? 17'(-q) : q;
    return res[15:0];
  endfunction

  logic [2:0]  state_r, state_nxt;
  logic [15:0] spacing_r;
  logic [2:0]  order_r;

  logic [7:0]  x_r, x_nxt;
  logic [7:0]  y_r, y_nxt;
  logic [5:0]  ex_r, ex_nxt;
  logic [2:0]  tcnt_r, tcnt_nxt;
  logic [2:0]  f_r, f_nxt;
  logic [2:0]  t_r, t_nxt;
  logic [1:0]  k_r, k_nxt;
  logic        u_wait_r, u_wait_nxt;
  logic signed [15:0] h_r [7];
  logic signed [16:0] vx_r, vx_nxt;
  logic signed [16:0] vy_r, vy_nxt;
  logic [hvn_pkg::SQ_W-1:0] sq_r [3];
  logic [hvn_pkg::N2_W-1:0] n2_r, n2_nxt;
  logic signed [hvn_pkg::ACC_W-1:0] acc_r [3];
  logic [15:0] res_r [3];
  logic        err_r, err_nxt;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_err_r;

  logic [3:0]    ord_eff;
  logic [NB-1:0] n_w;
  logic [NB-1:0] in_x, in_y;
  logic          in_inside;
  logic          acc_in;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic [8:0]    px, py;
  logic [8:0]    xc, yc;
  logic          e0, e12, e34, e5;
  logic          load_out;

  logic                        u_start;
  logic                        u_done;
  logic [hvn_pkg::UNIT_W-1:0]  u_r;
  logic signed [16:0]          sq_op;
  logic [16:0]                 sq_neg;
  logic [15:0]                 sq_mag;
  logic [hvn_pkg::SQ_W-1:0]    sq_val;
  logic                        comp_neg;
  logic signed [hvn_pkg::ACC_W-1:0] u_signed;
  logic signed [16:0]          tvx, tvy;

  assign ord_eff   = ({1'b0, order_r} > MAX_ORD4) ? MAX_ORD4 : {1'b0, order_r};
  assign n_w       = NB'(1) << ord_eff;
  assign in_x      = NB'(in_tdata[7:0]);
  assign in_y      = NB'(in_tdata[15:8]);
  assign in_inside = (in_x <= n_w) && (in_y <= n_w);
  assign in_tready = (state_r == S_IDLE);
  assign acc_in    = in_tvalid && in_tready;

  assign ram_we    = acc_in && (in_tuser == hvn_pkg::OP_WRITE) && in_inside;
  assign ram_waddr = addr_of({1'b0, in_tdata[7:0]}, {1'b0, in_tdata[15:8]});

  assign e0  = (in_x < n_w) && (in_y < n_w);
  assign e12 = (in_x != '0) && (in_y < n_w);
  assign e34 = (in_x < n_w) && (in_y != '0);
  assign e5  = (in_x != '0) && (in_y != '0);

  // Neighbor order: center, (x,y+1), (x+1,y), (x-1,y), (x-1,y+1), (x,y-1), (x+1,y-1).
  assign xc = {1'b0, x_r};
  assign yc = {1'b0, y_r};
  always_comb begin
    px = xc;
    py = yc;
    case (f_r)
      3'd1: begin px = xc;        py = yc + 9'd1; end
      3'd2: begin px = xc + 9'd1; py = yc;        end
      3'd3: begin px = xc - 9'd1; py = yc;        end
      3'd4: begin px = xc - 9'd1; py = yc + 9'd1; end
      3'd5: begin px = xc;        py = yc - 9'd1; end
      3'd6: begin px = xc + 9'd1; py = yc - 9'd1; end
      default: begin px = xc; py = yc; end
    endcase
  end
  assign ram_raddr = addr_of(px, py);

  hvn_ram #(
    .WIDTH(hvn_pkg::HGT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_tdata[31:16]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    tvx = diff(h_r[0], h_r[2]);
    tvy = diff(h_r[1], h_r[0]);
    case (t_r)
      3'd0: begin tvx = diff(h_r[0], h_r[2]); tvy = diff(h_r[1], h_r[0]); end
      3'd1: begin tvx = diff(h_r[3], h_r[0]); tvy = diff(h_r[4], h_r[3]); end
      3'd2: begin tvx = diff(h_r[4], h_r[1]); tvy = diff(h_r[1], h_r[0]); end
      3'd3: begin tvx = diff(h_r[5], h_r[6]); tvy = diff(h_r[0], h_r[5]); end
      3'd4: begin tvx = diff(h_r[0], h_r[2]); tvy = diff(h_r[2], h_r[6]); end
      default: begin tvx = diff(h_r[3], h_r[0]); tvy = diff(h_r[0], h_r[5]); end
    endcase
  end

  always_comb begin
    case (k_r)
      2'd0:    sq_op = vx_r;
      2'd1:    sq_op = vy_r;
      default: sq_op = $signed({1'b0, spacing_r});
    endcase
    sq_neg = 17'(-sq_op);
    sq_mag = sq_op[16] ? sq_neg[15:0] : sq_op[15:0];
    sq_val = hvn_pkg::SQ_W'(sq_mag) * hvn_pkg::SQ_W'(sq_mag);
  end

  assign u_start  = (state_r == S_UNIT) && !u_wait_r;
  assign comp_neg = (k_r == 2'd0) ? vx_r[16] : ((k_r == 2'd1) ? vy_r[16] : 1'b0);
  assign u_signed = comp_neg ? -$signed(hvn_pkg::ACC_W'(u_r)) : $signed(hvn_pkg::ACC_W'(u_r));

  hvn_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .start(u_start),
    .m    (sq_r[k_r]),
    .n2   (n2_r),
    .done (u_done),
    .r    (u_r)
  );

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    ex_nxt     = ex_r;
    tcnt_nxt   = tcnt_r;
    f_nxt      = f_r;
    t_nxt      = t_r;
    k_nxt      = k_r;
    u_wait_nxt = u_wait_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    n2_nxt     = n2_r;
    err_nxt    = err_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in && (in_tuser == hvn_pkg::OP_READ)) begin
          x_nxt    = in_tdata[7:0];
          y_nxt    = in_tdata[15:8];
          ex_nxt   = {e5, e34, e34, e12, e12, e0};
          tcnt_nxt = 3'(e0) + 3'(e5) + 3'({e12, 1'b0}) + 3'({e34, 1'b0});
          f_nxt    = 3'd0;
          t_nxt    = 3'd0;
          err_nxt  = !in_inside;
          state_nxt = in_inside ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        f_nxt = f_r + 3'd1;
        if (f_r == 3'd7) begin
          state_nxt = S_TRI;
        end
      end
      S_TRI: begin
        if (ex_r[t_r]) begin
          vx_nxt    = tvx;
          vy_nxt    = tvy;
          n2_nxt    = '0;
          k_nxt     = 2'd0;
          state_nxt = S_SQ;
        end else if (t_r == 3'd5) begin
          k_nxt     = 2'd0;
          state_nxt = S_AVG;
        end else begin
          t_nxt = t_r + 3'd1;
        end
      end
      S_SQ: begin
        n2_nxt = n2_r + hvn_pkg::N2_W'(sq_val);
        if (k_r == 2'd2) begin
          k_nxt      = 2'd0;
          u_wait_nxt = 1'b0;
          state_nxt  = S_UNIT;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_UNIT: begin
        if (u_start) begin
          u_wait_nxt = 1'b1;
        end
        if (u_done) begin
          u_wait_nxt = 1'b0;
          if (k_r == 2'd2) begin
            k_nxt = 2'd0;
            if (t_r == 3'd5) begin
              state_nxt = S_AVG;
            end else begin
              t_nxt     = t_r + 3'd1;
              state_nxt = S_TRI;
            end
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_AVG: begin
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spacing_r   <= hvn_pkg::SPACING_RST;
      order_r     <= hvn_pkg::ORDER_RST;
      u_wait_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      u_wait_r <= u_wait_nxt;
      if (cfg_we) begin
        unique case (cfg_index[0])
          hvn_pkg::CFG_SPACING: spacing_r <= cfg_wdata;
          hvn_pkg::CFG_ORDER:   order_r   <= cfg_wdata[2:0];
          default:              spacing_r <= spacing_r;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    ex_r   <= ex_nxt;
    tcnt_r <= tcnt_nxt;
    f_r    <= f_nxt;
    t_r    <= t_nxt;
    k_r    <= k_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    n2_r   <= n2_nxt;
    err_r  <= err_nxt;
    if (state_r == S_FETCH && f_r != 3'd0) begin
      h_r[f_r - 3'd1] <= ram_rdata;
    end
    if (state_r == S_SQ) begin
      sq_r[k_r] <= sq_val;
    end
    if (state_r == S_IDLE) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
      acc_r[2] <= '0;
      res_r[0] <= '0;
      res_r[1] <= '0;
      res_r[2] <= '0;
    end else if (state_r == S_UNIT && u_done) begin
      acc_r[k_r] <= acc_r[k_r] + u_signed;
    end else if (state_r == S_AVG) begin
      res_r[k_r] <= avg_comp(acc_r[k_r], tcnt_r);
    end
    if (load_out) begin
      out_data_r <= {res_r[2], res_r[1], res_r[0]};
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

`ifndef SYNTH
  a_unit_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (state_r == S_UNIT) && u_wait_r)
    else $error("normal unit finished without a pending request");

  a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && (in_tuser == hvn_pkg::OP_READ)) |=> !in_tready)
    else $error("input accepted while a read is still in work");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_tready |=> (state_r == S_DONE))
    else $error("finished result overwrote an untaken output");
`endif

endmodule
